// File: design/wap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wap_pkg - shared definitions for the weighted average predictor
// Window size, derived widths and the sequencer state type.
// ----------------------------------------------------------------------------
package wap_pkg;

	localparam int WIN    = 16;
	localparam int SLOT_W = $clog2(WIN);
	localparam int CNT_W  = $clog2(WIN + 1);
	localparam int WSUM_W = $clog2(WIN * (WIN + 1) / 2 + 1);
	localparam int MAE_W  = 16 + CNT_W;
	localparam int ACC_W  = 17 + WSUM_W;
	localparam int DIV_N  = ACC_W - 1;
	localparam int DIV_CW = $clog2(DIV_N);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_SETUP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// File: design/weighted_average_predictor_with_mae.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_average_predictor_with_mae - linearly weighted forecast with MAE
// Sample and forecast rings in memories, window walk, bit-serial division.
// ----------------------------------------------------------------------------
// Each accepted sample is written to the sample ring, then the window is
// walked once: one sample-ring port reads slots in order for the mean
// absolute error against the forecast ring, the other reads back from the
// newest sample for the weighted sum. Two restoring dividers then run side by
// side, one quotient bit per cycle; no new sample is taken while the walk and
// the divisions run. The result sits in an output register, so the next sample
// is taken while it waits; forecast slots not yet written read as zero through
// per-entry valid flags.
// ----------------------------------------------------------------------------
module weighted_average_predictor_with_mae
	import wap_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] prediction,
	output logic [15:0] mean_abs_error,
	output logic [4:0]  samples_held
);

	state_t state_q, state_d;

	logic [15:0] sample_ring   [WIN];
	logic [15:0] forecast_ring [WIN];
	logic [WIN-1:0] fvalid_q;

	logic [SLOT_W-1:0] write_slot_q, newest_q;
	logic [CNT_W-1:0]  fill_q, idx_q;
	logic [DIV_CW-1:0] dcnt_q;

	logic [SLOT_W-1:0] rd_a, rd_b;
	logic [CNT_W-1:0]  b_sum;
	logic              walk_done, div_last, out_free, accept;

	logic              rd_vld_s1, fc_ok_s1;
	logic [15:0]       smp_a_s1, smp_b_s1, fc_s1;
	logic [CNT_W-1:0]  wgt_s1;

	logic [MAE_W-1:0]  mae_sum_q;
	logic signed [ACC_W-1:0] wacc_q;

	logic [15:0]       fc_eff;
	logic signed [16:0] diff;
	logic [15:0]       abs_diff;
	logic signed [16+CNT_W:0] prod;

	logic [2*CNT_W-1:0] wprod;
	logic [WSUM_W-1:0]  wsum_q;
	logic               neg_q;
	logic [DIV_N-1:0]   num_a_q, num_b_q;
	logic [WSUM_W:0]    rem_a_q, rem_b_q;
	logic [WSUM_W:0]    t_a, t_b, div_a, div_b;
	logic               qa, qb;
	logic [DIV_N-1:0]   wabs;
	logic [DIV_N-1:0]   pred_mag;
	logic [15:0]        pred_val;

	logic [15:0] prediction_q, mae_q;
	logic [4:0]  held_q;
	logic        out_valid_q;

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign walk_done = (idx_q == fill_q);
	assign div_last  = (dcnt_q == DIV_CW'(DIV_N - 1));

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_done) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- ring addressing ----------------
	assign b_sum = CNT_W'(newest_q) + CNT_W'(WIN) - idx_q;

	always_comb begin
		rd_a = idx_q[SLOT_W-1:0];
		if (idx_q > CNT_W'(newest_q)) begin
			rd_b = b_sum[SLOT_W-1:0];
		end else begin
			rd_b = newest_q - idx_q[SLOT_W-1:0];
		end
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (accept) sample_ring[write_slot_q] <= sample;
		smp_a_s1 <= sample_ring[rd_a];
		smp_b_s1 <= sample_ring[rd_b];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) forecast_ring[write_slot_q] <= pred_val;
		fc_s1 <= forecast_ring[rd_a];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			newest_q     <= '0;
			fill_q       <= '0;
			idx_q        <= '0;
			dcnt_q       <= '0;
			fvalid_q     <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_WALK) && !walk_done;
			if (accept) begin
				newest_q     <= write_slot_q;
				write_slot_q <= (write_slot_q == SLOT_W'(WIN - 1)) ? '0 : write_slot_q + 1'b1;
				if (fill_q < CNT_W'(WIN)) fill_q <= fill_q + 1'b1;
				idx_q <= '0;
			end else if (state_q == ST_WALK && !walk_done) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_SETUP) begin
				dcnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q            <= 1'b1;
				fvalid_q[write_slot_q] <= 1'b1;
			end
		end
	end

	// ---------------- window walk datapath ----------------
	always_ff @(posedge clk) begin
		fc_ok_s1 <= fvalid_q[rd_a];
		wgt_s1   <= fill_q - idx_q;
	end

	assign fc_eff   = fc_ok_s1 ? fc_s1 : 16'd0;
	assign diff     = $signed({fc_eff[15], fc_eff}) - $signed({smp_a_s1[15], smp_a_s1});
	assign abs_diff = diff[16] ? 16'(-diff) : diff[15:0];
	assign prod     = $signed(smp_b_s1) * $signed({1'b0, wgt_s1});

	always_ff @(posedge clk) begin
		if (accept) begin
			mae_sum_q <= '0;
			wacc_q    <= '0;
		end else if (rd_vld_s1) begin
			mae_sum_q <= mae_sum_q + MAE_W'(abs_diff);
			wacc_q    <= wacc_q + ACC_W'(prod);
		end
	end

	// ---------------- dividers ----------------
	assign wprod = (2 * CNT_W)'(fill_q) * ((2 * CNT_W)'(fill_q) + 1'b1);
	assign wabs  = wacc_q[ACC_W-1] ? DIV_N'(-wacc_q) : DIV_N'(wacc_q);
	assign div_a = (WSUM_W + 1)'(fill_q);
	assign div_b = {1'b0, wsum_q};
	assign t_a   = {rem_a_q[WSUM_W-1:0], num_a_q[DIV_N-1]};
	assign t_b   = {rem_b_q[WSUM_W-1:0], num_b_q[DIV_N-1]};
	assign qa    = (t_a >= div_a);
	assign qb    = (t_b >= div_b);

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			wsum_q  <= WSUM_W'(wprod >> 1);
			neg_q   <= wacc_q[ACC_W-1];
			num_a_q <= DIV_N'(mae_sum_q);
			num_b_q <= wabs;
			rem_a_q <= '0;
			rem_b_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_a_q <= qa ? t_a - div_a : t_a;
			rem_b_q <= qb ? t_b - div_b : t_b;
			num_a_q <= {num_a_q[DIV_N-2:0], qa};
			num_b_q <= {num_b_q[DIV_N-2:0], qb};
		end
	end

	// truncate toward zero: negate the magnitude quotient
	assign pred_mag = neg_q ? -num_b_q : num_b_q;
	assign pred_val = pred_mag[15:0];

	// ---------------- output register ----------------
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			prediction_q <= pred_val;
			mae_q        <= (num_a_q > DIV_N'(16'hFFFF)) ? 16'hFFFF : num_a_q[15:0];
			held_q       <= 5'(fill_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign prediction     = prediction_q;
	assign mean_abs_error = mae_q;
	assign samples_held   = held_q;

endmodule
